>>> rtl/wstd_pkg.sv
// shared types and codes of the work-stealing task deque
// no dependencies; imported by wstd_ring, work_stealing_task_deque_core and tb_top
package wstd_pkg;

  localparam int HANDLE_W = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;   // width of reported fill and taken counts
  localparam int TOTAL_W  = 32;
  localparam int MAX_TAKE = 32;  // most handles one steal removes

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEAL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // packed result word: handle, taken, fill, three totals, pad to bytes
  localparam int OUT_DATA_W = 144;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [TOTAL_W-1:0]  total_t;

endpackage

>>> rtl/wstd_ring.sv
// handle store of the deque: one write port, one registered read port
// depends on wstd_pkg
module wstd_ring #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wstd_pkg::handle_t          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output wstd_pkg::handle_t          rd_data
);
  import wstd_pkg::*;

  handle_t mem [DEPTH];
  handle_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/wstd_addr.sv
// shared ring address unit: (base + offset) modulo the store depth
// depends on nothing, not even wstd_pkg; pure logic
module wstd_addr #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] pos
);
  localparam int AW = $clog2(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  // both operands are below the depth, so one subtract folds the sum back
  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = sum - (AW+1)'(DEPTH);
    if (sum >= (AW+1)'(DEPTH)) begin
      pos = wrapped[AW-1:0];
    end else begin
      pos = sum[AW-1:0];
    end
  end

endmodule

>>> rtl/work_stealing_task_deque_core.sv
// work-stealing task deque, top level: sequencer, counters, result register
// push, status query, full or empty cases: result register loaded on acceptance; pop: store read, then result register
// steal of n handles: one store read and one result word per handle
// input is held off while a pop or steal runs and while the result register waits
// back-to-back pushes and queries run at one word per cycle with the receiver ready
// sync active-low reset clears pointers, counts, totals and sequencer, not the store
module work_stealing_task_deque_core #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wstd_pkg::HANDLE_W-1:0]      in_tdata,   // [31:0] task_handle
  input  logic [wstd_pkg::CMD_W-1:0]         in_tuser,   // [1:0] command
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] out_handle, [38:32] taken_total, [45:39] fill_count,
  // [77:46] push_total, [109:78] pop_total, [141:110] steal_total, [143:142] zero
  output logic [wstd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,  // run_last
  output logic [2:0]                         out_tuser   // [1:0] status, [2] handle_valid
);
  import wstd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // ready for a word
  localparam logic [1:0] S_POP   = 2'd1;  // popped handle read, advance head
  localparam logic [1:0] S_SRD   = 2'd2;  // issue next steal read
  localparam logic [1:0] S_SWAIT = 2'd3;  // steal handle read, hand it out

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  total_t             push_r, push_nxt;
  total_t             pop_r, pop_nxt;
  total_t             steal_r, steal_nxt;
  logic [AW-1:0]      soff_r, soff_nxt;     // ring offset of next stolen handle
  logic [COUNT_W-1:0] left_r, left_nxt;     // stolen handles still to read
  logic [COUNT_W-1:0] take_r, take_nxt;     // handles taken by this steal

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  handle_t            o_handle_r, o_handle_nxt;
  logic               o_hvalid_r, o_hvalid_nxt;
  logic               o_last_r, o_last_nxt;
  logic [COUNT_W-1:0] o_taken_r, o_taken_nxt;
  logic [COUNT_W-1:0] o_fill_r, o_fill_nxt;
  total_t             o_push_r, o_push_nxt;
  total_t             o_pop_r, o_pop_nxt;
  total_t             o_steal_r, o_steal_nxt;

  // shared address unit and store ports
  logic [AW-1:0]      addr_off;
  logic [AW-1:0]      addr_pos;
  logic               wr_en;
  logic               rd_en;
  handle_t            rd_data;

  logic               accept;
  logic               out_free;
  logic               load;
  logic [CMD_W-1:0]   cmd;
  logic [31:0]        half32;
  logic [31:0]        take32;
  logic [31:0]        first32;
  logic [31:0]        fill32;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser;

  // steal size: half the held count, at least one, at most the run limit
  always_comb begin
    half32 = 32'(held_r) >> 1;
    if (half32 == 32'd0) begin
      take32 = 32'd1;
    end else if (half32 > 32'(MAX_TAKE)) begin
      take32 = 32'(MAX_TAKE);
    end else begin
      take32 = half32;
    end
    first32 = 32'(held_r) - take32;
  end

  // offset into the shared address unit for each step
  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (cmd == CMD_PUSH) begin
          addr_off = held_r[AW-1:0];  // tail slot, below depth when not full
        end else begin
          addr_off = '0;              // head slot for a pop
        end
      end
      S_POP:   addr_off = AW'(1);
      S_SRD:   addr_off = soff_r;
      default: addr_off = '0;
    endcase
  end

  wstd_addr #(.DEPTH(DEPTH)) u_addr (
    .base   (head_r),
    .offset (addr_off),
    .pos    (addr_pos)
  );

  wstd_ring #(.DEPTH(DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_pos),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (addr_pos),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    held_nxt     = held_r;
    push_nxt     = push_r;
    pop_nxt      = pop_r;
    steal_nxt    = steal_r;
    soff_nxt     = soff_r;
    left_nxt     = left_r;
    take_nxt     = take_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    load         = 1'b0;
    o_status_nxt = ST_OK;
    o_handle_nxt = '0;
    o_hvalid_nxt = 1'b0;
    o_last_nxt   = 1'b1;
    o_taken_nxt  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (held_r >= CW'(DEPTH)) begin
                o_status_nxt = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                held_nxt = held_r + CW'(1);
                push_nxt = push_r + TOTAL_W'(1);
              end
            end
            CMD_POP: begin
              if (held_r == '0) begin
                load         = 1'b1;
                o_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                held_nxt  = held_r - CW'(1);
                pop_nxt   = pop_r + TOTAL_W'(1);
                state_nxt = S_POP;
              end
            end
            CMD_STEAL: begin
              if (held_r == '0) begin
                load         = 1'b1;
                o_status_nxt = ST_EMPTY;
              end else begin
                // stolen run starts at the first slot past what remains
                held_nxt  = first32[CW-1:0];
                soff_nxt  = first32[AW-1:0];
                take_nxt  = take32[COUNT_W-1:0];
                left_nxt  = take32[COUNT_W-1:0];
                steal_nxt = steal_r + TOTAL_W'(1);
                state_nxt = S_SRD;
              end
            end
            default: begin
              load = 1'b1;  // status query
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          load         = 1'b1;
          o_handle_nxt = rd_data;
          o_hvalid_nxt = 1'b1;
          o_taken_nxt  = COUNT_W'(1);
          head_nxt     = addr_pos;
          state_nxt    = S_IDLE;
        end
      end

      S_SRD: begin
        rd_en     = 1'b1;
        soff_nxt  = soff_r + AW'(1);
        left_nxt  = left_r - COUNT_W'(1);
        state_nxt = S_SWAIT;
      end

      S_SWAIT: begin
        if (out_free) begin
          load         = 1'b1;
          o_handle_nxt = rd_data;
          o_hvalid_nxt = 1'b1;
          o_taken_nxt  = take_r;
          o_last_nxt   = (left_r == '0);
          if (left_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // every result reports the state after the whole operation
  assign fill32      = 32'(held_nxt);
  assign o_fill_nxt  = fill32[COUNT_W-1:0];
  assign o_push_nxt  = push_nxt;
  assign o_pop_nxt   = pop_nxt;
  assign o_steal_nxt = steal_nxt;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      held_r      <= '0;
      push_r      <= '0;
      pop_r       <= '0;
      steal_r     <= '0;
      soff_r      <= '0;
      left_r      <= '0;
      take_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      push_r      <= push_nxt;
      pop_r       <= pop_nxt;
      steal_r     <= steal_nxt;
      soff_r      <= soff_nxt;
      left_r      <= left_nxt;
      take_r      <= take_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      o_status_r <= o_status_nxt;
      o_handle_r <= o_handle_nxt;
      o_hvalid_r <= o_hvalid_nxt;
      o_last_r   <= o_last_nxt;
      o_taken_r  <= o_taken_nxt;
      o_fill_r   <= o_fill_nxt;
      o_push_r   <= o_push_nxt;
      o_pop_r    <= o_pop_nxt;
      o_steal_r  <= o_steal_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = {o_hvalid_r, o_status_r};
  assign out_tdata  = {2'b00, o_steal_r, o_pop_r, o_push_r, o_fill_r, o_taken_r, o_handle_r};

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// testbench for work_stealing_task_deque_core: push, pop, steal-half and status query words
// depends on wstd_pkg and the core rtl; keeps its own deque model and checks every result word
module tb_top;
  import wstd_pkg::*;

  localparam int TB_DEPTH    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;     // one long receiver stall to back up the core
  localparam int TAIL_CYCLES = 80;      // idle cycles after the last result word

  typedef struct {
    logic [CMD_W-1:0] cmd;
    handle_t          handle;
  } deque_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    handle_t             handle;
    logic                handle_ok;
    logic                last;
    logic [COUNT_W-1:0]  taken;
    logic [COUNT_W-1:0]  fill;
    total_t              pushes;
    total_t              pops;
    total_t              steals;
  } deque_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [HANDLE_W-1:0]   in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = CMD_QUERY;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [2:0]            out_tuser;

  work_stealing_task_deque_core #(.DEPTH(TB_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // stimulus and expectation stores
  deque_cmd_t    pending_cmds[$];
  deque_cmd_t    offered;
  deque_result_t expected_words[$];

  int items_planned  = 0;
  int items_accepted = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  logic idle_on;

  // private copy of the deque state
  handle_t     slot_mem[TB_DEPTH];
  int unsigned head_pos  = 0;
  int unsigned held      = 0;
  total_t      push_cnt  = '0;
  total_t      pop_cnt   = '0;
  total_t      steal_cnt = '0;

  // idle in stretches of 80 words out of every 120, never in the last 60 words
  assign idle_on = ((items_accepted / 40) % 3 != 2) && (items_planned - items_accepted > 60);

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // every word of one command reports the state after the whole command
  task automatic queue_result(logic [STATUS_W-1:0] status, handle_t h, logic ok,
                              logic last, int unsigned taken);
    deque_result_t r;
    r.status    = status;
    r.handle    = h;
    r.handle_ok = ok;
    r.last      = last;
    r.taken     = taken[COUNT_W-1:0];
    r.fill      = held[COUNT_W-1:0];
    r.pushes    = push_cnt;
    r.pops      = pop_cnt;
    r.steals    = steal_cnt;
    expected_words.push_back(r);
  endtask

  task automatic predict_results(deque_cmd_t c);
    handle_t     grabbed[MAX_TAKE];
    handle_t     h;
    int unsigned take;
    int unsigned first;
    case (c.cmd)
      CMD_PUSH: begin
        if (held >= TB_DEPTH) begin
          queue_result(ST_FULL, '0, 1'b0, 1'b1, 0);
        end else begin
          slot_mem[(head_pos + held) % TB_DEPTH] = c.handle;
          held++;
          push_cnt++;
          queue_result(ST_OK, '0, 1'b0, 1'b1, 0);
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          queue_result(ST_EMPTY, '0, 1'b0, 1'b1, 0);
        end else begin
          h = slot_mem[head_pos];
          head_pos = (head_pos + 1) % TB_DEPTH;
          held--;
          pop_cnt++;
          queue_result(ST_OK, h, 1'b1, 1'b1, 1);
        end
      end
      CMD_STEAL: begin
        if (held == 0) begin
          queue_result(ST_EMPTY, '0, 1'b0, 1'b1, 0);
        end else begin
          // half from the tail end, at least one, at most MAX_TAKE
          take = held / 2;
          if (take == 0) take = 1;
          if (take > MAX_TAKE) take = MAX_TAKE;
          first = held - take;
          for (int i = 0; i < take; i++)
            grabbed[i] = slot_mem[(head_pos + first + i) % TB_DEPTH];
          held -= take;
          steal_cnt++;
          for (int i = 0; i < take; i++)
            queue_result(ST_OK, grabbed[i], 1'b1, (i + 1 == take), take);
        end
      end
      default: begin
        queue_result(ST_OK, '0, 1'b0, 1'b1, 0);
      end
    endcase
  endtask

  task automatic add_cmd(logic [CMD_W-1:0] cmd, handle_t h);
    deque_cmd_t c;
    c.cmd    = cmd;
    c.handle = h;
    pending_cmds.push_back(c);
  endtask

  function automatic handle_t pick_handle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // segment mixes: fill heavy, drain heavy, even mix
  task automatic add_segment(int kind, int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      case (kind)
        0:       add_cmd(r < 90 ? CMD_PUSH : (r < 95 ? CMD_POP : CMD_QUERY), pick_handle());
        1:       add_cmd(r < 40 ? CMD_POP : (r < 85 ? CMD_STEAL : (r < 95 ? CMD_PUSH : CMD_QUERY)),
                         pick_handle());
        default: add_cmd(r < 45 ? CMD_PUSH : (r < 65 ? CMD_POP : (r < 85 ? CMD_STEAL : CMD_QUERY)),
                         pick_handle());
      endcase
    end
  endtask

  // driver: offers queued command words, holds them until taken, idles in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_results(offered);
        items_accepted++;
      end
      if (in_tvalid && !in_tready) begin
        // word still waiting, keep it on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 10);
        in_tvalid <= 1'b0;
      end else begin
        offered = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= offered.handle;
        in_tuser  <= offered.cmd;
      end
    end
  end

  // receiver ready: random stall bursts plus one long hold so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && items_accepted >= 150) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: each result word against the oldest expectation
  always @(posedge clk) begin
    deque_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_error($sformatf("result word with none expected, data %h", out_tdata));
      end else begin
        w = expected_words.pop_front();
        check_field("status",       out_tuser[1:0],      w.status);
        check_field("handle_valid", out_tuser[2],        w.handle_ok);
        check_field("run_last",     out_tlast,           w.last);
        check_field("out_handle",   out_tdata[31:0],     w.handle);
        check_field("taken_total",  out_tdata[38:32],    w.taken);
        check_field("fill_count",   out_tdata[45:39],    w.fill);
        check_field("push_total",   out_tdata[77:46],    w.pushes);
        check_field("pop_total",    out_tdata[109:78],   w.pops);
        check_field("steal_total",  out_tdata[141:110],  w.steals);
        check_field("pad",          out_tdata[143:142],  2'b00);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // directed: empty cases, extreme handles, every command, steals of one
    add_cmd(CMD_POP,   32'h0000_0000);
    add_cmd(CMD_STEAL, 32'hFFFF_FFFF);
    add_cmd(CMD_QUERY, 32'hFFFF_FFFF);
    add_cmd(CMD_PUSH,  32'h0000_0000);
    add_cmd(CMD_PUSH,  32'hFFFF_FFFF);
    add_cmd(CMD_PUSH,  32'h5555_5555);
    add_cmd(CMD_PUSH,  32'hAAAA_AAAA);
    add_cmd(CMD_QUERY, 32'h1234_5678);
    add_cmd(CMD_POP,   32'hFFFF_FFFF);
    add_cmd(CMD_STEAL, 32'h0000_0000);   // three held, takes one
    add_cmd(CMD_STEAL, 32'h0000_0000);   // two held, takes one
    add_cmd(CMD_STEAL, 32'h0000_0000);   // one held, still takes one
    add_cmd(CMD_POP,   32'h0000_0000);
    add_cmd(CMD_STEAL, 32'h0000_0000);
    for (int i = 0; i < 7; i++)
      add_cmd(CMD_PUSH, $urandom);
    add_cmd(CMD_STEAL, 32'hFFFF_FFFF);   // seven held, multi-word steal of three
    add_cmd(CMD_POP,   32'h0000_0000);
    add_cmd(CMD_STEAL, 32'h0000_0000);

    // fill past full, then the largest steal, then a drain-heavy segment
    for (int i = 0; i < 68; i++)
      add_cmd(CMD_PUSH, pick_handle());
    add_cmd(CMD_QUERY, pick_handle());
    add_cmd(CMD_STEAL, pick_handle());
    add_segment(1, 30);

    // random segments until at least 445 words are queued
    while (pending_cmds.size() < 445)
      add_segment($urandom_range(0, 2), $urandom_range(15, 60));
    items_planned = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_planned) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wstd_pkg.sv
rtl/wstd_ring.sv
rtl/wstd_addr.sv
rtl/work_stealing_task_deque_core.sv
test/tb_top.sv
